// ===== sv/csrmv_pkg.sv =====
package csrmv_pkg;

  // Field widths
  localparam int unsigned ColW     = 10;
  localparam int unsigned ValW     = 32;
  localparam int unsigned RowW     = 16;
  localparam int unsigned SumW     = 64;
  localparam int unsigned NumRowsW = 17;

  // Saturation limits of the Q32.32 accumulator
  localparam logic signed [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
  localparam logic signed [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};

  // Item kinds carried by the mode field
  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_NZ    = 2'd1,
    MODE_EMPTY = 2'd2
  } mode_e;

  typedef struct packed {
    logic [1:0]             mode;
    logic [ColW-1:0]        column;
    logic signed [ValW-1:0] value;
    logic                   end_of_row;
  } in_item_t;

  typedef struct packed {
    logic [RowW-1:0]        row_index;
    logic signed [SumW-1:0] row_sum;
    logic                   final_row;
  } out_item_t;

  // Operands handed from the memory read stage to the multiply-accumulate unit
  typedef struct packed {
    logic                   valid;
    logic                   empty_row;
    logic                   end_of_row;
    logic signed [ValW-1:0] value;
    logic signed [ValW-1:0] x;
  } mac_req_t;

  // Signed add that clamps at the 64-bit limits
  function automatic logic signed [SumW-1:0] sat_add(input logic signed [SumW-1:0] a,
                                                     input logic signed [SumW-1:0] b);
    logic signed [SumW-1:0] s;
    s = a + b;
    if ((a[SumW-1] == b[SumW-1]) && (s[SumW-1] != a[SumW-1])) begin
      return a[SumW-1] ? SumMin : SumMax;
    end
    return s;
  endfunction

endpackage

// ===== sv/csr_sparse_matvec.sv =====
// A row result passes the read stage, the multiply stage and the result register after the beat that ends the row.
// Throughput: one input beat per cycle unless stalled; loads, nonzeros and empty rows mix freely.
// Input stalls only when the result register and both internal stages are full.
// Reset clears pipeline valids, the row accumulator and counter, and sets num_rows to 1.
// The vector memory is not cleared; an entry must be loaded before it is used.
module csr_sparse_matvec #(
  parameter int unsigned VECTOR_DEPTH = 1024,
  parameter int unsigned MAX_ROWS     = 65536
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  csrmv_pkg::in_item_t            in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output csrmv_pkg::out_item_t           out_data_o,
  input  logic                           cfg_we_i,
  input  logic [csrmv_pkg::NumRowsW-1:0] cfg_wdata_i
);
  import csrmv_pkg::*;

  localparam int unsigned AddrW   = $clog2(VECTOR_DEPTH);
  localparam int unsigned ColExtW = ColW + AddrW;

  logic [ValW-1:0] vec_mem [VECTOR_DEPTH];
  logic [ValW-1:0] rd_q;

  logic [ColExtW-1:0] col_ext;
  logic               col_ok;
  logic [AddrW-1:0]   addr;
  logic               accept, is_load, is_nz, is_empty;

  // Read stage
  logic                   s1_v_q, s1_v_d;
  logic                   s1_empty_q, s1_eor_q, s1_ok_q;
  logic signed [ValW-1:0] s1_val_q;
  logic                   s1_take;
  mac_req_t               req;

  logic [NumRowsW-1:0] num_rows_q;

  // Decode the input beat
  assign col_ext  = ColExtW'(in_data_i.column);
  assign col_ok   = col_ext < ColExtW'(VECTOR_DEPTH);
  assign addr     = col_ext[AddrW-1:0];
  assign accept   = in_valid_i && in_ready_o;
  assign is_load  = (in_data_i.mode == MODE_LOAD);
  assign is_nz    = (in_data_i.mode == MODE_NZ);
  assign is_empty = (in_data_i.mode == MODE_EMPTY);

  assign in_ready_o = !s1_v_q || s1_take;

  // Write loads and read nonzero operands; one beat per edge keeps them ordered
  always_ff @(posedge clk_i) begin
    if (accept && is_load && col_ok) begin
      vec_mem[addr] <= in_data_i.value;
    end
    if (accept && is_nz) begin
      rd_q <= vec_mem[addr];
    end
  end

  // Advance the read stage
  always_comb begin
    s1_v_d = s1_v_q && !s1_take;
    if (accept) begin
      s1_v_d = is_nz || is_empty;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (is_nz || is_empty)) begin
      s1_empty_q <= is_empty;
      s1_eor_q   <= in_data_i.end_of_row;
      s1_ok_q    <= col_ok;
      s1_val_q   <= in_data_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q     <= 1'b0;
      num_rows_q <= NumRowsW'(1);
    end else begin
      s1_v_q <= s1_v_d;
      if (cfg_we_i) begin
        num_rows_q <= cfg_wdata_i;
      end
    end
  end

  // Out-of-range columns multiply by zero
  assign req.valid      = s1_v_q;
  assign req.empty_row  = s1_empty_q;
  assign req.end_of_row = s1_eor_q;
  assign req.value      = s1_val_q;
  assign req.x          = s1_ok_q ? rd_q : '0;

  csrmv_mac #(
    .MAX_ROWS (MAX_ROWS)
  ) u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .req_ready_o (s1_take),
    .num_rows_i  (num_rows_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  a_nz_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_nz |=> s1_v_q)
    else $error("accepted nonzero did not enter the read stage");

  a_load_bypass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_load && !s1_v_q |=> !s1_v_q)
    else $error("vector load occupied the read stage");

  a_rd_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q && !s1_take |=> s1_v_q && $stable(rd_q))
    else $error("read data changed while the read stage was stalled");
`endif

endmodule

// ===== sv/csrmv_mac.sv =====
module csrmv_mac #(
  parameter int unsigned MAX_ROWS = 65536
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  csrmv_pkg::mac_req_t                 req_i,
  output logic                                req_ready_o,
  input  logic [csrmv_pkg::NumRowsW-1:0]      num_rows_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output csrmv_pkg::out_item_t                out_data_o
);
  import csrmv_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_ROWS);
  localparam int unsigned CmpW = (CntW > NumRowsW) ? CntW : NumRowsW;

  // Multiply stage
  logic                   s2_v_q, s2_v_d;
  logic                   s2_empty_q, s2_eor_q;
  logic signed [SumW-1:0] s2_prod_q;
  logic                   s2_emits, s2_take, s2_free, s2_load;

  // Accumulate stage and output register
  logic signed [SumW-1:0] acc_q, acc_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   out_v_q, out_v_d;
  out_item_t              out_q, out_d;
  logic                   out_free;

  logic signed [ValW-1:0] op_a, op_b;
  logic signed [SumW-1:0] prod_c, sum_c;
  logic [CmpW-1:0]        cnt_w, last_w;
  logic                   fin, wrap;

  assign out_free    = !out_v_q || out_ready_i;
  assign s2_emits    = s2_empty_q || s2_eor_q;
  assign s2_take     = s2_v_q && (!s2_emits || out_free);
  assign s2_free     = !s2_v_q || s2_take;
  assign s2_load     = req_i.valid && s2_free;
  assign req_ready_o = s2_free;

  // Form the exact Q32.32 product
  assign op_a   = req_i.value;
  assign op_b   = req_i.x;
  assign prod_c = op_a * op_b;

  assign s2_v_d = s2_load ? 1'b1 : (s2_take ? 1'b0 : s2_v_q);

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      s2_empty_q <= req_i.empty_row;
      s2_eor_q   <= req_i.end_of_row;
      s2_prod_q  <= prod_c;
    end
  end

  // Row bookkeeping
  assign sum_c  = sat_add(acc_q, s2_prod_q);
  assign cnt_w  = CmpW'(cnt_q);
  assign last_w = CmpW'(NumRowsW'(num_rows_i - NumRowsW'(1)));
  assign fin    = (cnt_w == last_w);
  assign wrap   = fin || (cnt_q == CntW'(MAX_ROWS - 1));

  always_comb begin
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    out_d   = out_q;
    out_v_d = out_v_q && !out_ready_i;
    if (s2_take) begin
      if (s2_emits) begin
        acc_d           = '0;
        out_v_d         = 1'b1;
        out_d.row_index = cnt_w[RowW-1:0];
        out_d.row_sum   = s2_empty_q ? '0 : sum_c;
        out_d.final_row = fin;
        cnt_d           = wrap ? '0 : cnt_q + CntW'(1);
      end else begin
        acc_d = sum_c;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      acc_q   <= '0;
      cnt_q   <= '0;
    end else begin
      s2_v_q  <= s2_v_d;
      out_v_q <= out_v_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
    end
  end

  // Hold the result beat until taken
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_cnt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(cnt_q))
    else $error("row counter moved while a result beat was stalled");

  a_acc_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_take && s2_emits |=> acc_q == '0)
    else $error("accumulator not cleared after a row was emitted");

  a_prod_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q && !s2_take |=> s2_v_q && $stable(s2_prod_q))
    else $error("stalled product was lost or overwritten");
`endif

endmodule
